// ----- hdl/lrr_pkg.sv -----
// Shared types, constants and codes for the ranged random number unit.
// No dependencies; every other file of the unit but the checker imports this package.
package lrr_pkg;

    // Generator recurrence: state = state * LCG_MUL + LCG_ADD (mod 2^32).
    localparam int unsigned VAL_W     = 32;
    localparam logic [VAL_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [VAL_W-1:0] LCG_ADD = 32'd1013904223;
    localparam logic [VAL_W-1:0] SEED_RESET = 32'd0;

    // The integer draw is the upper half of the state, the fraction its top 24 bits.
    localparam int unsigned DRAW_W    = 16;
    localparam int unsigned FRAC_W    = 24;
    localparam int unsigned FRAC_LSB  = VAL_W - FRAC_W;
    localparam int unsigned DIV_CNT_W = $clog2(DRAW_W);

    // Request queue between the front and back ends.
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // Register file: one 32-bit register at byte address 0.
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned REG_SEL_BIT = 2;
    localparam logic REG_IDX_SEED = 1'b0;

    // Request type codes.
    localparam logic REQ_INT  = 1'b0;
    localparam logic REQ_FRAC = 1'b1;

    // A classified request: ordered low bound and the span high - low + 1,
    // where a span of zero stands for the full 2^32 range.
    typedef struct packed {
        logic             req_type;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] span;
    } t_req_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/lrr_front.sv -----
// Front end: accepts requests, orders the bounds and works out the span.
// Depends on lrr_pkg.
module lrr_front (
    input  logic                      i_valid,
    input  logic                      i_req_type,
    input  logic signed [31:0]        i_range_low,
    input  logic signed [31:0]        i_range_high,
    input  lrr_pkg::t_q_status        i_q_status,
    output logic                      o_stall,
    output logic                      o_push,
    output lrr_pkg::t_req_entry       o_entry
);
    import lrr_pkg::*;

    logic             swap;
    logic [VAL_W-1:0] lo_ord;
    logic [VAL_W-1:0] hi_ord;

    assign swap   = (i_range_high < i_range_low);
    assign lo_ord = swap ? VAL_W'(i_range_high) : VAL_W'(i_range_low);
    assign hi_ord = swap ? VAL_W'(i_range_low)  : VAL_W'(i_range_high);

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        o_entry.req_type = i_req_type;
        o_entry.lo       = lo_ord;
        // Wraps to zero over the full signed range, which the back end reads as 2^32.
        o_entry.span     = hi_ord - lo_ord + VAL_W'(1);
    end

endmodule

// ----- hdl/lrr_fifo.sv -----
// Short request queue that decouples the front end from the back end.
// Depends on lrr_pkg.
module lrr_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lrr_pkg::t_req_entry   i_entry,
    input  logic                  i_pop,
    output lrr_pkg::t_req_entry   o_entry,
    output lrr_pkg::t_q_status    o_status
);
    import lrr_pkg::*;

    t_req_entry          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic                do_push;
    logic                do_pop;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/lrr_back.sv -----
// Back end: holds the generator state, advances it per request, reduces an integer
// request's draw modulo the span one bit per cycle and registers the result. Depends on lrr_pkg.
module lrr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_wr,
    input  logic [31:0]                 i_seed,
    input  lrr_pkg::t_req_entry         i_entry,
    input  lrr_pkg::t_q_status          i_q_status,
    output logic                        o_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic signed [31:0]          o_int_value,
    output logic [23:0]                 o_fraction
);
    import lrr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

    t_state                r_state,  n_state;
    logic [VAL_W-1:0]      r_lcg,    n_lcg;
    logic                  r_req,    n_req;
    logic [VAL_W-1:0]      r_lo,     n_lo;
    logic [VAL_W-1:0]      r_span,   n_span;
    logic [DRAW_W-1:0]     r_draw,   n_draw;
    logic [DRAW_W-1:0]     r_rem,    n_rem;
    logic [DIV_CNT_W-1:0]  r_cnt,    n_cnt;
    logic [FRAC_W-1:0]     r_frac,   n_frac;
    logic                  r_out_valid, n_out_valid;
    logic [VAL_W-1:0]      r_int,    n_int;
    logic [FRAC_W-1:0]     r_out_frac, n_out_frac;

    logic [VAL_W-1:0]      lcg_next;
    logic [DRAW_W:0]       trial;
    logic                  take;
    logic                  out_free;

    assign lcg_next = r_lcg * LCG_MUL + LCG_ADD;
    assign trial    = {r_rem, r_draw[DRAW_W-1]};
    assign take     = (r_span != '0) && ({{(VAL_W-DRAW_W-1){1'b0}}, trial} >= r_span);
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_status.empty;

    always_comb begin
        n_state     = r_state;
        n_lcg       = r_lcg;
        n_req       = r_req;
        n_lo        = r_lo;
        n_span      = r_span;
        n_draw      = r_draw;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_frac      = r_frac;
        n_out_valid = r_out_valid && i_stall;
        n_int       = r_int;
        n_out_frac  = r_out_frac;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    n_lcg   = lcg_next;
                    n_req   = i_entry.req_type;
                    n_lo    = i_entry.lo;
                    n_span  = i_entry.span;
                    n_draw  = lcg_next[VAL_W-1 -: DRAW_W];
                    n_frac  = lcg_next[VAL_W-1 -: FRAC_W];
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = (i_entry.req_type == REQ_FRAC) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = take ? DRAW_W'(trial - r_span[DRAW_W:0]) : trial[DRAW_W-1:0];
                n_draw = {r_draw[DRAW_W-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DRAW_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_req == REQ_FRAC) begin
                        n_int      = '0;
                        n_out_frac = r_frac;
                    end else begin
                        n_int      = r_lo + {{(VAL_W-DRAW_W){1'b0}}, r_rem};
                        n_out_frac = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (i_seed_wr) begin
            n_lcg = i_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_lcg       <= SEED_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lcg       <= n_lcg;
            r_req       <= n_req;
            r_lo        <= n_lo;
            r_span      <= n_span;
            r_draw      <= n_draw;
            r_rem       <= n_rem;
            r_cnt       <= n_cnt;
            r_frac      <= n_frac;
            r_int       <= n_int;
            r_out_frac  <= n_out_frac;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_int_value = $signed(r_int);
    assign o_fraction  = r_out_frac;

endmodule

// ----- hdl/lcg_ranged_random_unit.sv -----
// Ranged random number unit: an integer request goes through the queue, the step in the back end
// that takes the request, the 16-step modulo loop, and the step that registers the result; the
// back end takes no new request until it has registered the last result.
// Fraction requests skip the modulo loop.
// Up to two requests queue ahead of the back end, so requests are still taken while it works.
// Synchronous active-low reset empties the queue, drops any result and clears seed and state to 0.
module lcg_ranged_random_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel.
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_req_type,
    input  logic signed [31:0]          i_range_low,
    input  logic signed [31:0]          i_range_high,
    // Result channel.
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_int_value,
    output logic [23:0]                 o_fraction,
    // Register port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lrr_pkg::*;

    // The front end orders the two bounds and forms the span in the cycle a
    // request is accepted, and writes the classified request into the queue.
    // The queue lets new requests arrive while the back end is busy or while
    // a finished result is still waiting to be taken.
    // The back end owns the generator state. It takes one request at a time,
    // advances the state, and for an integer request runs a restoring modulo
    // over the 16-bit draw, one bit per cycle, before the final addition of
    // the low bound. A span of zero means the full 32-bit range; no
    // subtraction ever happens then, so the draw is used unchanged.

    logic [VAL_W-1:0] r_seed;
    logic             seed_wr;
    logic             push;
    logic             pop;
    t_req_entry       front_entry;
    t_req_entry       q_entry;
    t_q_status        q_status;

    // The register is written in the access phase of a write. Writing the seed
    // also reloads the generator state in the back end.
    assign pready  = 1'b1;
    assign seed_wr = psel && penable && pwrite && pready && (paddr[REG_SEL_BIT] == REG_IDX_SEED);
    assign prdata  = (paddr[REG_SEL_BIT] == REG_IDX_SEED) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
        end else if (seed_wr) begin
            r_seed <= pwdata;
        end
    end

    lrr_front u_front (
        .i_valid      (i_valid),
        .i_req_type   (i_req_type),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_q_status   (q_status),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_entry      (front_entry)
    );

    lrr_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (front_entry),
        .i_pop    (pop),
        .o_entry  (q_entry),
        .o_status (q_status)
    );

    lrr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seed_wr   (seed_wr),
        .i_seed      (pwdata),
        .i_entry     (q_entry),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_int_value (o_int_value),
        .o_fraction  (o_fraction)
    );

endmodule

// ----- hdl/lrr_checker.sv -----
// Port-level checks for the ranged random number unit, bound to its top level.
// Depends on the top level's port names only.
module lrr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_int_value,
    input logic [23:0]        o_fraction,
    input logic               pready
);

    // A result waiting on a stall stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A result is either an integer or a fraction, never both.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_int_value == 32'sd0) || (o_fraction == 24'd0))
        else $error("integer and fraction both non-zero");

    // Reset removes any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");

    // The register port never inserts wait states.
    a_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind lcg_ranged_random_unit lrr_checker u_lrr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_int_value (o_int_value),
    .o_fraction  (o_fraction),
    .pready      (pready)
);

// ----- test/lcg_ranged_random_unit_tb.sv -----
// Self-checking testbench for the ranged random number unit: integer and fraction requests,
// seed writes and read-back through the register port, each result checked against a local model.
// Depends on lrr_pkg and lcg_ranged_random_unit.
module lcg_ranged_random_unit_tb;
    import lrr_pkg::*;

    localparam int unsigned HALF_PERIOD   = 10;
    localparam int unsigned RESET_CYCLES  = 10;
    // Quiet time after the last result, so that the back end is idle before the seed is touched.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned IDLE_PERCENT  = 11;
    localparam int unsigned PHASE_ITEMS   = 200;
    localparam int unsigned PHASES        = 4;

    localparam logic [ADDR_W-1:0] SEED_ADDR  = ADDR_W'(REG_IDX_SEED) << REG_SEL_BIT;
    // The next word up holds no register, so writes there must change nothing.
    localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(1) << REG_SEL_BIT;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] int_value;
        logic [FRAC_W-1:0]  fraction;
    } t_draw;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_valid      = 1'b0;
    logic                       o_stall;
    logic                       i_req_type   = REQ_INT;
    logic signed [31:0]         i_range_low  = '0;
    logic signed [31:0]         i_range_high = '0;
    logic                       o_valid;
    logic                       i_stall      = 1'b0;
    logic signed [31:0]         o_int_value;
    logic [23:0]                o_fraction;
    logic                       psel         = 1'b0;
    logic                       penable      = 1'b0;
    logic                       pwrite       = 1'b0;
    logic [ADDR_W-1:0]          paddr        = '0;
    logic [31:0]                pwdata       = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // Local copy of the generator: the seed register and the running state.
    logic [VAL_W-1:0] seed_value = SEED_RESET;
    logic [VAL_W-1:0] gen_state  = SEED_RESET;

    // Draws that have been requested but whose results have not yet come out, oldest first.
    t_draw pending_draws[$];

    int fault_count = 0;
    // While set, neither side inserts idle cycles, giving a long stretch at full rate.
    bit steady = 1'b0;

    lcg_ranged_random_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_int_value  (o_int_value),
        .o_fraction   (o_fraction),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // A generous ceiling on the run time of the whole test.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Advances the generator by one step and works out the draw that a request yields.
    // Reversed bounds are put in order first; a span that wraps to zero covers all 2^32
    // values, so the upper half of the state is then added to the low bound unreduced.
    function automatic t_draw next_draw(logic req, logic signed [31:0] lo_in,
                                        logic signed [31:0] hi_in);
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [31:0]        span;
        logic [31:0]        pick;
        logic [31:0]        offset;
        t_draw              draw;
        lo = lo_in;
        hi = hi_in;
        draw = '0;
        gen_state = gen_state * LCG_MUL + LCG_ADD;
        if (req == REQ_FRAC) begin
            draw.fraction = gen_state[VAL_W-1 -: FRAC_W];
        end else begin
            if (hi < lo) begin
                lo = hi_in;
                hi = lo_in;
            end
            span = hi - lo + 32'd1;
            pick = {{(VAL_W-DRAW_W){1'b0}}, gen_state[VAL_W-1 -: DRAW_W]};
            offset = (span == '0) ? pick : pick % span;
            draw.int_value = lo + offset;
        end
        return draw;
    endfunction

    // Offers one request, after a random idle gap unless running steady. Valid stays high
    // on return so that a following request can go out in the very next cycle. The draw is
    // predicted at the edge of acceptance, well before its result can appear.
    task automatic send_request(logic req, logic signed [31:0] lo, logic signed [31:0] hi);
        t_draw owed;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_range_low  <= lo;
        i_range_high <= hi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        owed = next_draw(req, lo, hi);
        pending_draws.insert(pending_draws.size(), owed);
    endtask

    // Stops offering requests and waits until every result has come out and the back end
    // has had time to fall quiet.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle until pready. A seed write reloads
    // the generator state; a write to an address with no register changes nothing.
    task automatic write_register(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((addr >> REG_SEL_BIT) == REG_IDX_SEED) begin
            seed_value = data;
            gen_state  = data;
        end
        @(posedge i_clk);
    endtask

    // Reads the seed register back; it holds the last value written, not the running state.
    task automatic check_seed_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SEED_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== seed_value) begin
            $error("seed: expected %08h, actual %08h", seed_value, prdata);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // The receiving side holds off results now and then.
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Every result taken is compared with the oldest draw still owed.
    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_draws.size() == 0) begin
                $error("unexpected result: int_value %0d, fraction %06h",
                       o_int_value, o_fraction);
                fault_count++;
            end else begin
                want = pending_draws.pop_front();
                if (o_int_value !== want.int_value) begin
                    $error("int_value: expected %0d, actual %0d", want.int_value, o_int_value);
                    fault_count++;
                end
                if (o_fraction !== want.fraction) begin
                    $error("fraction: expected %06h, actual %06h", want.fraction, o_fraction);
                    fault_count++;
                end
            end
        end
    end

    // Straight out of reset the state is zero. Covers the edges of the integer range:
    // the full range whichever way round, equal bounds at both extremes and in the middle,
    // reversed bounds, spans of two, of 2^31 and of 2^32 - 1, and fraction requests whose
    // bounds are all zeros, all ones and the extremes, which must be ignored.
    task automatic test_reset_state();
        check_seed_readback();
        send_request(REQ_INT,  INT_MIN,      INT_MAX);
        send_request(REQ_INT,  INT_MAX,      INT_MIN);
        send_request(REQ_INT,  32'sd5,       32'sd5);
        send_request(REQ_INT,  INT_MIN,      INT_MIN);
        send_request(REQ_INT,  INT_MAX,      INT_MAX);
        send_request(REQ_INT,  32'sd10,      -32'sd10);
        send_request(REQ_INT,  32'sd0,       32'sd1);
        send_request(REQ_INT,  -32'sd1,      32'sd0);
        send_request(REQ_INT,  32'sd0,       INT_MAX);
        send_request(REQ_INT,  INT_MIN,      -32'sd1);
        send_request(REQ_INT,  INT_MIN,      INT_MAX - 32'sd1);
        send_request(REQ_INT,  INT_MAX,      INT_MIN + 32'sd1);
        send_request(REQ_FRAC, 32'sd0,       32'sd0);
        send_request(REQ_FRAC, -32'sd1,      -32'sd1);
        send_request(REQ_FRAC, INT_MAX,      INT_MIN);
        send_request(REQ_INT,  -32'sd7,      32'sd1000);
        settle();
    endtask

    // Seed writes at both extremes and the top bit alone, the extremes read back, with a write to
    // the unused address in between that must leave both seed and state untouched.
    task automatic test_seed_register();
        write_register(SEED_ADDR, 32'hFFFF_FFFF);
        check_seed_readback();
        send_request(REQ_FRAC, 32'sd0,  32'sd0);
        send_request(REQ_INT,  INT_MIN, INT_MAX);
        send_request(REQ_INT,  32'sd0,  32'sd100);
        settle();
        write_register(SPARE_ADDR, $urandom);
        check_seed_readback();
        send_request(REQ_INT,  32'sd100, -32'sd100);
        send_request(REQ_FRAC, 32'sd0,   32'sd0);
        settle();
        write_register(SEED_ADDR, 32'h8000_0000);
        send_request(REQ_INT,  -32'sd3, 32'sd3);
        settle();
        write_register(SEED_ADDR, 32'h0000_0000);
        check_seed_readback();
        send_request(REQ_FRAC, 32'sd0,  32'sd0);
        send_request(REQ_INT,  32'sd1,  32'sd6);
        settle();
    endtask

    // Random requests in several phases, each with a fresh random seed. About a third are
    // fraction requests; the integer ones mix fully random bounds, narrow spans around a
    // random point in either order, and bounds near the two extremes. One phase runs with
    // no idling on either side.
    task automatic test_random_requests();
        int                 kind;
        logic               req;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] swap;
        for (int phase = 0; phase < PHASES; phase++) begin
            write_register(SEED_ADDR, $urandom);
            check_seed_readback();
            steady = (phase == 2);
            repeat (PHASE_ITEMS) begin
                kind = $urandom_range(99);
                req  = (kind < 30) ? REQ_FRAC : REQ_INT;
                lo   = $urandom;
                hi   = $urandom;
                if (kind >= 30 && kind < 60) begin
                    hi = lo + 32'($urandom_range(300));
                end else if (kind >= 60 && kind < 72) begin
                    lo = INT_MIN + 32'($urandom_range(3));
                    hi = INT_MAX - 32'($urandom_range(3));
                end
                if ($urandom_range(1) == 1) begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
                send_request(req, lo, hi);
            end
            settle();
        end
        steady = 1'b0;
    endtask

    // Reset is held low at the start and then released, then each test runs in turn. Every test
    // ends with all results in and the block quiet, so the verdict can be given at once.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_seed_register();
        test_random_requests();
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/lrr_pkg.sv
hdl/lrr_front.sv
hdl/lrr_fifo.sv
hdl/lrr_back.sv
hdl/lcg_ranged_random_unit.sv
hdl/lrr_checker.sv
test/lcg_ranged_random_unit_tb.sv
